FILE: rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package utf8d_pkg;

	// Field widths.
	localparam int CODE_W = 21;
	localparam int UNIT_W = 16;

	// Depth of the queue between the front and the back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	// Lead byte ranges.
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD_END  = 8'hF8;

	// Masks applied to continuation bytes.
	localparam logic [7:0] OVL3_MASK = 8'h20;
	localparam logic [7:0] OVL4_MASK = 8'h30;
	localparam logic [7:0] CONT_MASK = 8'h3F;

	// Code point limits and surrogate bases.
	localparam logic [CODE_W-1:0] MAX_CP    = 21'h10FFFF;
	localparam logic [CODE_W-1:0] SUPP_BASE = 21'h010000;
	localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
	localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEAD  = 3'd1,
		ST_BAD_CONT  = 3'd2,
		ST_OVERLONG  = 3'd3,
		ST_RANGE     = 3'd4,
		ST_TRUNCATED = 3'd5
	} status_t;

	// One decoded character or error, as passed from front to back.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		status_t           status;
		logic              pair;
		logic              done;
	} entry_t;

endpackage

`default_nettype wire

FILE: rtl/utf8_decoder_to_utf16_or_utf32_top.sv
// UTF-8 decoder, top level: outputs code points or UTF-16 code units.
// Instantiates utf8d_front, utf8d_fifo and utf8d_back; uses utf8d_pkg.
//
// Input channel (in_valid/in_ready) carries one byte per transfer with a
// string_end mark on the last byte of each string. Output channel
// (out_valid/out_ready) carries one result per transfer: a code value, a
// status, run_last on the final result caused by a byte and string_done
// on results of a string's final byte. Bytes in the middle of a sequence,
// and bytes after an error up to the string end, give no result.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes
// utf16_output; write it only while no work is in flight.
// A result passes through the queue into the output register; the low
// half of a surrogate pair follows its high half from that register.
// The input takes one byte per cycle while the queue has room; the output
// register gives one result per cycle while out_ready is high, a surrogate
// pair giving two results.
// A two-entry queue sits between decode and output, so bytes keep flowing
// while a result waits; when the receiver stalls and the queue fills,
// in_ready drops. Reset clears the sequence state, the queue, the output
// register's valid and pending flags and selects code point output.
`default_nettype none

module utf8_decoder_to_utf16_or_utf32_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          utf16_output,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          string_end,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [utf8d_pkg::CODE_W-1:0]       code_value,
	output logic [2:0]                         status,
	output logic                               run_last,
	output logic                               string_done
);

	logic              utf16_q;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;
	utf8d_pkg::entry_t push_entry;
	utf8d_pkg::entry_t head;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			utf16_q <= utf16_output;
		end
	end

	// Decode front.
	utf8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.string_end (string_end),
		.utf16      (utf16_q),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue between front and back.
	utf8d_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	// Result back.
	utf8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_value  (code_value),
		.status      (status),
		.run_last    (run_last),
		.string_done (string_done)
	);

endmodule

`default_nettype wire

FILE: rtl/utf8d_fifo.sv
// Small register queue that decouples the decoder front from the result back.
// Uses utf8d_pkg for the entry type and the depth.
`default_nettype none

module utf8d_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  utf8d_pkg::entry_t     push_entry,
	input  wire logic             pop,
	output utf8d_pkg::entry_t     head,
	output logic                  full,
	output logic                  empty
);

	utf8d_pkg::entry_t                 mem_q [utf8d_pkg::Q_DEPTH];
	logic [utf8d_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [utf8d_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [utf8d_pkg::Q_CNT_W-1:0]     count_q;

	assign full  = (count_q == utf8d_pkg::Q_CNT_W'(utf8d_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Entry storage; no reset needed on the payload.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == utf8d_pkg::Q_PTR_W'(utf8d_pkg::Q_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == utf8d_pkg::Q_PTR_W'(utf8d_pkg::Q_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The front never writes a full queue, the back never reads an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/utf8d_front.sv
// Decoder front: accepts bytes, tracks the multibyte sequence and classifies it.
// Pushes one completed character or one error per result into the queue; uses utf8d_pkg.
`default_nettype none

module utf8d_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       data_byte,
	input  wire logic             string_end,
	input  wire logic             utf16,
	input  wire logic             full,
	output logic                  push,
	output utf8d_pkg::entry_t     push_entry
);

	typedef enum logic [1:0] {
		OVL_NONE = 2'd0,
		OVL_E0   = 2'd1,
		OVL_F0   = 2'd2
	} ovl_t;

	logic [1:0]                    rem_q, rem_d;
	logic [utf8d_pkg::CODE_W-1:0]  part_q, part_d, part_next;
	ovl_t                          ovl_q, ovl_d;
	logic                          drop_q, drop_d;
	logic                          accept;
	logic                          lead_ok;
	logic                          fault;
	utf8d_pkg::status_t            fault_st;
	logic                          emit_now;
	logic [utf8d_pkg::CODE_W-1:0]  emit_cp;

	// One result at most per byte, so a free queue slot is enough to take a byte.
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	// Per-byte decode: sequence tracking, checks and result selection.
	always_comb begin
		rem_d      = rem_q;
		part_d     = part_q;
		ovl_d      = ovl_q;
		drop_d     = drop_q;
		lead_ok    = 1'b0;
		fault      = 1'b0;
		fault_st   = utf8d_pkg::ST_OK;
		emit_now   = 1'b0;
		emit_cp    = '0;
		part_next  = {part_q[utf8d_pkg::CODE_W-7:0], data_byte[5:0] & utf8d_pkg::CONT_MASK[5:0]};
		push       = 1'b0;
		push_entry = '0;
		push_entry.done = string_end;

		if (accept) begin
			if (drop_q) begin
				// Skip the rest of a failed string.
				if (string_end) begin
					drop_d = 1'b0;
				end
			end else if (rem_q == 2'd0) begin
				// Expecting a lead byte.
				if (!data_byte[7]) begin
					emit_now = 1'b1;
					emit_cp  = utf8d_pkg::CODE_W'(data_byte);
				end else if (data_byte >= utf8d_pkg::LEAD2_MIN &&
						data_byte < utf8d_pkg::LEAD3_MIN) begin
					lead_ok = 1'b1;
					part_d  = utf8d_pkg::CODE_W'(data_byte[4:0]);
					rem_d   = 2'd1;
					ovl_d   = OVL_NONE;
				end else if (data_byte >= utf8d_pkg::LEAD3_MIN &&
						data_byte < utf8d_pkg::LEAD4_MIN) begin
					lead_ok = 1'b1;
					part_d  = utf8d_pkg::CODE_W'(data_byte[3:0]);
					rem_d   = 2'd2;
					ovl_d   = (data_byte[3:0] == 4'd0) ? OVL_E0 : OVL_NONE;
				end else if (data_byte >= utf8d_pkg::LEAD4_MIN &&
						data_byte < utf8d_pkg::LEAD_END) begin
					lead_ok = 1'b1;
					part_d  = utf8d_pkg::CODE_W'(data_byte[2:0]);
					rem_d   = 2'd3;
					ovl_d   = (data_byte[2:0] == 3'd0) ? OVL_F0 : OVL_NONE;
				end else begin
					fault    = 1'b1;
					fault_st = utf8d_pkg::ST_BAD_LEAD;
				end
				if (lead_ok && string_end) begin
					fault    = 1'b1;
					fault_st = utf8d_pkg::ST_TRUNCATED;
				end
			end else begin
				// Expecting a continuation byte.
				if (data_byte[7:6] != 2'b10) begin
					fault    = 1'b1;
					fault_st = utf8d_pkg::ST_BAD_CONT;
				end else if (ovl_q == OVL_E0 &&
						(data_byte & utf8d_pkg::OVL3_MASK) == 8'h00) begin
					fault    = 1'b1;
					fault_st = utf8d_pkg::ST_OVERLONG;
				end else if (ovl_q == OVL_F0 &&
						(data_byte & utf8d_pkg::OVL4_MASK) == 8'h00) begin
					fault    = 1'b1;
					fault_st = utf8d_pkg::ST_OVERLONG;
				end else begin
					ovl_d  = OVL_NONE;
					part_d = part_next;
					rem_d  = rem_q - 2'd1;
					if (rem_q == 2'd1) begin
						emit_now = 1'b1;
						emit_cp  = part_next;
					end else if (string_end) begin
						fault    = 1'b1;
						fault_st = utf8d_pkg::ST_TRUNCATED;
					end
				end
			end

			// In UTF-16 mode, a completed character beyond the UTF-16 range is an error.
			if (emit_now && utf16 && emit_cp > utf8d_pkg::MAX_CP) begin
				fault    = 1'b1;
				fault_st = utf8d_pkg::ST_RANGE;
			end

			if (fault) begin
				rem_d  = 2'd0;
				part_d = '0;
				ovl_d  = OVL_NONE;
				drop_d = !string_end;
				push   = 1'b1;
				push_entry.status = fault_st;
			end else if (emit_now) begin
				rem_d  = 2'd0;
				part_d = '0;
				ovl_d  = OVL_NONE;
				push   = 1'b1;
				push_entry.code   = emit_cp;
				push_entry.status = utf8d_pkg::ST_OK;
				push_entry.pair   = utf16 && (emit_cp[utf8d_pkg::CODE_W-1:16] != '0);
			end
		end
	end

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 2'd0;
			part_q <= '0;
			ovl_q  <= OVL_NONE;
			drop_q <= 1'b0;
		end else begin
			rem_q  <= rem_d;
			part_q <= part_d;
			ovl_q  <= ovl_d;
			drop_q <= drop_d;
		end
	end

	// Dropped bytes never produce a result.
	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> !push)
		else $error("result produced while dropping");

endmodule

`default_nettype wire

FILE: rtl/utf8d_back.sv
// Decoder back: takes queued characters and errors and drives the result register.
// Splits supplementary code points into surrogate pairs; uses utf8d_pkg.
`default_nettype none

module utf8d_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  utf8d_pkg::entry_t                  head,
	input  wire logic                          empty,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [utf8d_pkg::CODE_W-1:0]       code_value,
	output logic [2:0]                         status,
	output logic                               run_last,
	output logic                               string_done
);

	logic                          out_valid_q;
	logic [utf8d_pkg::CODE_W-1:0]  code_q;
	utf8d_pkg::status_t            status_q;
	logic                          run_last_q;
	logic                          done_q;
	logic                          pend_q;
	logic [utf8d_pkg::UNIT_W-1:0]  low_q;
	logic                          load_ok;
	logic [utf8d_pkg::CODE_W-1:0]  supp;
	logic [utf8d_pkg::UNIT_W-1:0]  hi_unit;
	logic [utf8d_pkg::UNIT_W-1:0]  lo_unit;

	assign load_ok = !out_valid_q || out_ready;
	assign pop     = load_ok && !pend_q && !empty;

	// Surrogate halves of a supplementary code point.
	assign supp    = head.code - utf8d_pkg::SUPP_BASE;
	assign hi_unit = utf8d_pkg::HI_SURR | {6'd0, supp[19:10]};
	assign lo_unit = utf8d_pkg::LO_SURR | {6'd0, supp[9:0]};

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_q) begin
				code_q     <= utf8d_pkg::CODE_W'(low_q);
				status_q   <= utf8d_pkg::ST_OK;
				run_last_q <= 1'b1;
			end else if (!empty) begin
				code_q     <= head.pair ? utf8d_pkg::CODE_W'(hi_unit) : head.code;
				status_q   <= head.status;
				run_last_q <= !head.pair;
				done_q     <= head.done;
				low_q      <= lo_unit;
			end
		end
	end

	// Result valid and the pending low surrogate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (load_ok) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= !empty;
				pend_q      <= !empty && head.pair;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign code_value  = code_q;
	assign status      = status_q;
	assign run_last    = run_last_q;
	assign string_done = done_q;

	// A high surrogate transfer is followed at once by its low half.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !run_last_q) |=>
		(out_valid_q && run_last_q && status_q == utf8d_pkg::ST_OK))
		else $error("low surrogate did not follow high surrogate");

	// Error results carry a zero value and always close their byte.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != utf8d_pkg::ST_OK) |-> (code_q == '0 && run_last_q))
		else $error("error result with nonzero value or open run");

endmodule

`default_nettype wire

FILE: bench/tb_utf8_decoder_to_utf16_or_utf32_top.sv
// Self-checking testbench for the UTF-8 decoder top level.
// Depends on utf8d_pkg and utf8_decoder_to_utf16_or_utf32_top; predicts every result in-bench.
`default_nettype none

module tb_utf8_decoder_to_utf16_or_utf32_top;

	localparam int RESET_CYCLES   = 11;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	// Pending continuation check after an E0 or F0 lead.
	typedef enum logic [1:0] {
		OVL_NONE     = 2'd0,
		OVL_AFTER_E0 = 2'd1,
		OVL_AFTER_F0 = 2'd2
	} ovl_kind_t;

	// One predicted output transfer.
	typedef struct packed {
		logic [utf8d_pkg::CODE_W-1:0] code;
		utf8d_pkg::status_t           st;
		logic                         last;
		logic                         done;
	} result_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          cfg_valid    = 1'b0;
	logic                          utf16_output = 1'b0;
	logic                          in_valid     = 1'b0;
	logic [7:0]                    data_byte    = 8'h00;
	logic                          string_end   = 1'b0;
	logic                          out_ready    = 1'b0;
	logic                          cfg_ready;
	logic                          in_ready;
	logic                          out_valid;
	logic [utf8d_pkg::CODE_W-1:0]  code_value;
	logic [2:0]                    status;
	logic                          run_last;
	logic                          string_done;

	// Decoder state as the bench sees it.
	logic                          utf16_mode = 1'b0;
	logic [1:0]                    seq_left   = 2'd0;
	logic [utf8d_pkg::CODE_W-1:0]  seq_code   = '0;
	ovl_kind_t                     ovl_kind   = OVL_NONE;
	logic                          dropping   = 1'b0;

	result_t             decoded_q[$];
	logic [7:0]          str_bytes[$];

	// Pacing controls shared by the tests, the byte sender and the receiver pacer.
	int                  ready_pct    = 100;
	bit                  gaps_on      = 1'b0;
	bit                  hold_request = 1'b0;
	int                  burst_left   = 0;

	int                  items_used   = 0;
	int                  n_results    = 0;
	int                  n_pairs      = 0;
	int                  n_err_results = 0;
	int                  mismatches   = 0;
	int                  quiet_cycles = 0;

	always #5 clk = ~clk;

	utf8_decoder_to_utf16_or_utf32_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.utf16_output(utf16_output),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.string_end  (string_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_value  (code_value),
		.status      (status),
		.run_last    (run_last),
		.string_done (string_done)
	);

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic void push_result(logic [utf8d_pkg::CODE_W-1:0] c,
			utf8d_pkg::status_t st, logic last, logic e);
		result_t r;
		r.code = c;
		r.st   = st;
		r.last = last;
		r.done = e;
		decoded_q = {decoded_q, r};
	endfunction

	// An error gives one result; the rest of the string is dropped unless this byte ends it.
	function automatic void report_error(utf8d_pkg::status_t st, logic e);
		seq_left = 2'd0;
		seq_code = '0;
		ovl_kind = OVL_NONE;
		dropping = !e;
		push_result('0, st, 1'b1, e);
	endfunction

	// A completed character becomes one code point, or one or two UTF-16 units, or a range error in UTF-16 mode.
	function automatic void finish_char(logic [utf8d_pkg::CODE_W-1:0] cp, logic e);
		logic [utf8d_pkg::CODE_W-1:0] offset;
		seq_left = 2'd0;
		seq_code = '0;
		ovl_kind = OVL_NONE;
		if (!utf16_mode || cp < utf8d_pkg::SUPP_BASE) begin
			if (utf16_mode && cp > utf8d_pkg::MAX_CP) begin
				report_error(utf8d_pkg::ST_RANGE, e);
			end else begin
				push_result(cp, utf8d_pkg::ST_OK, 1'b1, e);
			end
		end else if (cp > utf8d_pkg::MAX_CP) begin
			report_error(utf8d_pkg::ST_RANGE, e);
		end else begin
			offset = cp - utf8d_pkg::SUPP_BASE;
			push_result(utf8d_pkg::CODE_W'(utf8d_pkg::HI_SURR) + (offset >> 10),
				utf8d_pkg::ST_OK, 1'b0, e);
			push_result(utf8d_pkg::CODE_W'(utf8d_pkg::LO_SURR) +
				utf8d_pkg::CODE_W'(offset[9:0]), utf8d_pkg::ST_OK, 1'b1, e);
		end
	endfunction

	// Advance the decoder by one accepted byte and queue the results it causes.
	function automatic void decode_byte(logic [7:0] b, logic e);
		if (dropping) begin
			if (e)
				dropping = 1'b0;
			return;
		end
		if (seq_left == 2'd0) begin
			if (!b[7]) begin
				finish_char(utf8d_pkg::CODE_W'(b), e);
				return;
			end
			if (b >= utf8d_pkg::LEAD2_MIN && b < utf8d_pkg::LEAD3_MIN) begin
				seq_code = utf8d_pkg::CODE_W'(b[4:0]);
				seq_left = 2'd1;
				ovl_kind = OVL_NONE;
			end else if (b >= utf8d_pkg::LEAD3_MIN && b < utf8d_pkg::LEAD4_MIN) begin
				seq_code = utf8d_pkg::CODE_W'(b[3:0]);
				seq_left = 2'd2;
				ovl_kind = (b[3:0] == 4'd0) ? OVL_AFTER_E0 : OVL_NONE;
			end else if (b >= utf8d_pkg::LEAD4_MIN && b < utf8d_pkg::LEAD_END) begin
				seq_code = utf8d_pkg::CODE_W'(b[2:0]);
				seq_left = 2'd3;
				ovl_kind = (b[2:0] == 3'd0) ? OVL_AFTER_F0 : OVL_NONE;
			end else begin
				report_error(utf8d_pkg::ST_BAD_LEAD, e);
				return;
			end
			if (e)
				report_error(utf8d_pkg::ST_TRUNCATED, e);
			return;
		end
		// Continuation byte: range first, then the overlong check.
		if (b[7:6] != 2'b10) begin
			report_error(utf8d_pkg::ST_BAD_CONT, e);
			return;
		end
		if ((ovl_kind == OVL_AFTER_E0 && (b & utf8d_pkg::OVL3_MASK) == 8'h00) ||
				(ovl_kind == OVL_AFTER_F0 && (b & utf8d_pkg::OVL4_MASK) == 8'h00)) begin
			report_error(utf8d_pkg::ST_OVERLONG, e);
			return;
		end
		ovl_kind = OVL_NONE;
		seq_code = {seq_code[utf8d_pkg::CODE_W-7:0], b[5:0]};
		seq_left = seq_left - 2'd1;
		if (seq_left == 2'd0)
			finish_char(seq_code, e);
		else if (e)
			report_error(utf8d_pkg::ST_TRUNCATED, e);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one byte, with random gaps between bursts when gaps_on is set, and predict it once it transfers.
	task automatic send_byte(input logic [7:0] b, input logic e);
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid   <= 1'b1;
		data_byte  <= b;
		string_end <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_used++;
		decode_byte(b, e);
	endtask

	// Send the staged bytes; the last one carries the end mark when close is set.
	task automatic send_string(input bit close);
		foreach (str_bytes[i])
			send_byte(str_bytes[i], close && (i == str_bytes.size() - 1));
	endtask

	// Stop offering, wait for every predicted result, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		wait_idle();
		cfg_valid    <= 1'b1;
		utf16_output <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		utf16_mode = m;
	endtask

	function automatic logic [utf8d_pkg::CODE_W-1:0] random_code_point();
		case ($urandom_range(0, 9))
			0, 1: return utf8d_pkg::CODE_W'($urandom_range(0, 'h7F));
			2: return utf8d_pkg::CODE_W'($urandom_range('h80, 'h7FF));
			3, 4: return utf8d_pkg::CODE_W'($urandom_range('h800, 'hFFFF));
			5: return utf8d_pkg::CODE_W'($urandom_range('hD800, 'hDFFF));
			6, 7: return utf8d_pkg::CODE_W'($urandom_range('h10000, 'h10FFFF));
			8: begin
				case ($urandom_range(0, 7))
					0: return 21'h000000;
					1: return 21'h00007F;
					2: return 21'h000080;
					3: return 21'h0007FF;
					4: return 21'h000800;
					5: return 21'h00FFFF;
					6: return 21'h010000;
					default: return 21'h10FFFF;
				endcase
			end
			default: return utf8d_pkg::CODE_W'($urandom_range('h110000, 'h1FFFFF));
		endcase
	endfunction

	// Append one byte to the staged string.
	function automatic void stage_byte(logic [7:0] b);
		str_bytes = {str_bytes, b};
	endfunction

	// Shortest-form encoding of one code point.
	function automatic void push_char(logic [utf8d_pkg::CODE_W-1:0] cp);
		if (cp < 'h80) begin
			stage_byte(cp[7:0]);
		end else if (cp < 'h800) begin
			stage_byte({3'b110, cp[10:6]});
			stage_byte({2'b10, cp[5:0]});
		end else if (cp < 'h10000) begin
			stage_byte({4'b1110, cp[15:12]});
			stage_byte({2'b10, cp[11:6]});
			stage_byte({2'b10, cp[5:0]});
		end else begin
			stage_byte({5'b11110, cp[20:18]});
			stage_byte({2'b10, cp[17:12]});
			stage_byte({2'b10, cp[11:6]});
			stage_byte({2'b10, cp[5:0]});
		end
	endfunction

	// Mostly well-formed strings; the rest are noise, overlong forms, corrupted or cut short.
	task automatic random_string();
		int kind;
		int cut;
		kind = $urandom_range(0, 99);
		str_bytes.delete();
		if (kind < 8) begin
			repeat ($urandom_range(1, 6)) stage_byte(8'($urandom_range(0, 255)));
		end else begin
			if (kind < 14) begin
				case ($urandom_range(0, 2))
					0: begin
						stage_byte({7'b1100000, 1'($urandom_range(0, 1))});
						stage_byte({2'b10, 6'($urandom_range(0, 63))});
					end
					1: begin
						stage_byte(utf8d_pkg::LEAD3_MIN);
						stage_byte({3'b100, 5'($urandom_range(0, 31))});
						stage_byte({2'b10, 6'($urandom_range(0, 63))});
					end
					default: begin
						stage_byte(utf8d_pkg::LEAD4_MIN);
						stage_byte({4'b1000, 4'($urandom_range(0, 15))});
						stage_byte({2'b10, 6'($urandom_range(0, 63))});
						stage_byte({2'b10, 6'($urandom_range(0, 63))});
					end
				endcase
			end
			repeat ($urandom_range(1, 5)) push_char(random_code_point());
			if (kind >= 14 && kind < 26) begin
				str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
			end else if (kind >= 26 && kind < 34 && str_bytes.size() > 1) begin
				cut = $urandom_range(1, (str_bytes.size() > 3) ? 3 : str_bytes.size() - 1);
				repeat (cut) void'(str_bytes.pop_back());
			end
		end
		send_string(1'b1);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_valid_chars();
		write_mode(1'b0);
		ready_pct = 100;
		gaps_on   = 1'b1;
		str_bytes = {8'h00, 8'h7F};
		send_string(1'b1);
		// A surrogate code point is passed through unchecked.
		str_bytes = {8'hED, 8'hA0, 8'h80};
		send_string(1'b1);
		// The highest F7 lead gives 1FFFFF in code point mode.
		str_bytes = {8'hF7, 8'hBF, 8'hBF, 8'hBF};
		send_string(1'b1);
	endtask

	task automatic test_malformed();
		ready_pct = 50;
		// Overlong after F0, reported on the end-marked byte.
		str_bytes = {8'hF0, 8'h8F};
		send_string(1'b1);
		str_bytes = {8'hFF};
		send_string(1'b1);
		// Bad continuation wins over overlong, and over truncation on the end byte.
		str_bytes = {8'hE0, 8'h00};
		send_string(1'b1);
		str_bytes = {8'hC2};
		send_string(1'b1);
		// The error on the middle byte drops the rest of the string.
		str_bytes = {8'hC2, 8'h41, 8'h41};
		send_string(1'b1);
	endtask

	// The output mode is taken when the character completes, not at its lead.
	task automatic test_mode_switch_midchar();
		str_bytes = {8'hF0, 8'h90};
		send_string(1'b0);
		write_mode(1'b1);
		str_bytes = {8'h80, 8'h80};
		send_string(1'b1);
	endtask

	task automatic test_utf16_range();
		str_bytes = {8'hF4, 8'h90, 8'h80, 8'h80};
		send_string(1'b1);
	endtask

	task automatic test_random_stream(input logic mode, input int pct, input bit gaps,
			input int n_items);
		int goal;
		write_mode(mode);
		ready_pct = pct;
		gaps_on   = gaps;
		goal      = items_used + n_items;
		while (items_used < goal) random_string();
	endtask

	// The receiver holds off while bytes keep coming, so the input side must stall.
	task automatic test_receiver_holdoff();
		int goal;
		write_mode(1'b1);
		ready_pct    = 100;
		gaps_on      = 1'b0;
		hold_request = 1'b1;
		goal         = items_used + 80;
		while (items_used < goal) random_string();
	endtask

	// ------------------------------------------------------------------
	// Receiver pacing
	// ------------------------------------------------------------------

	initial begin : rx_pacer
		int run_left;
		int hold_left;
		run_left  = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				run_left = $urandom_range(0, 7);
				out_ready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				$error("unexpected result: code_value %h status %0d", code_value, status);
				mismatches++;
			end else begin
				want = decoded_q.pop_front();
				n_results++;
				if (!want.last)
					n_pairs++;
				if (want.st != utf8d_pkg::ST_OK)
					n_err_results++;
				if (code_value !== want.code) begin
					$error("code_value: expected %h, actual %h", want.code, code_value);
					mismatches++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					mismatches++;
				end
				if (run_last !== want.last) begin
					$error("run_last: expected %b, actual %b", want.last, run_last);
					mismatches++;
				end
				if (string_done !== want.done) begin
					$error("string_done: expected %b, actual %b", want.done, string_done);
					mismatches++;
				end
			end
		end
	end

	// Ends the run when no transfer happens on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("utf8_decoder_to_utf16_or_utf32_top regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_valid_chars();
		test_malformed();
		test_mode_switch_midchar();
		test_utf16_range();
		test_random_stream(1'b0, 100, 1'b0, 400);
		test_random_stream(1'b1, 60, 1'b1, 500);
		test_random_stream(1'b0, 40, 1'b1, 400);
		test_receiver_holdoff();
		test_random_stream(1'b1, 75, 1'b1, 250);
		wait_idle();
		if (decoded_q.size() != 0) begin
			$error("%0d expected results never arrived", decoded_q.size());
			mismatches++;
		end
		$display("Covered %0d input bytes and %0d results in both output modes,",
			items_used, n_results);
		$display("including %0d surrogate pairs, %0d error results and a %0d-cycle hold-off.",
			n_pairs, n_err_results, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("utf8_decoder_to_utf16_or_utf32_top regression: pass");
		end else begin
			$display("utf8_decoder_to_utf16_or_utf32_top regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: utf8_decoder_to_utf16_or_utf32_top.f
rtl/utf8d_pkg.sv
rtl/utf8d_fifo.sv
rtl/utf8d_front.sv
rtl/utf8d_back.sv
rtl/utf8_decoder_to_utf16_or_utf32_top.sv
bench/tb_utf8_decoder_to_utf16_or_utf32_top.sv
